>>> design/chpc_pkg.sv
// Coin hopper payout controller: shared types, mode codes, register indexes
// and reset values.
// No dependencies.
`default_nettype none

package chpc_pkg;

	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 16;
	localparam int CoinW     = 8;
	localparam int TicksW    = 16;
	localparam int NumLines  = 4;

	// register indexes
	localparam logic [CfgIdxW-1:0] RegCoinsLineOne   = 3'd0;
	localparam logic [CfgIdxW-1:0] RegCoinsLineTwo   = 3'd1;
	localparam logic [CfgIdxW-1:0] RegCoinsLineThree = 3'd2;
	localparam logic [CfgIdxW-1:0] RegCoinsLineFour  = 3'd3;
	localparam logic [CfgIdxW-1:0] RegTimeoutTicks   = 3'd4;

	// register reset values
	localparam logic [CoinW-1:0]  CoinsLineOneRst   = 8'd10;
	localparam logic [CoinW-1:0]  CoinsLineTwoRst   = 8'd20;
	localparam logic [CoinW-1:0]  CoinsLineThreeRst = 8'd50;
	localparam logic [CoinW-1:0]  CoinsLineFourRst  = 8'd100;
	localparam logic [TicksW-1:0] TimeoutTicksRst   = 16'd8000;

	localparam logic [TicksW-1:0] TicksMax = {TicksW{1'b1}};

	// controller modes
	localparam logic [1:0] ModeIdle   = 2'd0;
	localparam logic [1:0] ModeSpare  = 2'd1;
	localparam logic [1:0] ModePaying = 2'd2;
	localparam logic [1:0] ModeFault  = 2'd3;

	typedef struct packed {
		logic [NumLines-1:0][CoinW-1:0] coins_line;
		logic [TicksW-1:0]              timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic                service_active;
		logic [NumLines-1:0] lines;
		logic                coin_present;
	} tick_t;

	typedef struct packed {
		logic             motor_on;
		logic             accept_enabled;
		logic             paying;
		logic             fault;
		logic [CoinW-1:0] coins_paid;
		logic             payout_done;
	} result_t;

endpackage

`default_nettype wire

>>> design/chpc_tick_if.sv
// Coin hopper payout controller: input tick channel (valid/ready + sampled levels).
// Depends on nothing.
`default_nettype none

interface chpc_tick_if;
	logic valid;
	logic ready;
	logic service_active;
	logic line_one_active;
	logic line_two_active;
	logic line_three_active;
	logic line_four_active;
	logic coin_present;

	modport source (
		output valid, service_active, line_one_active, line_two_active,
		       line_three_active, line_four_active, coin_present,
		input  ready
	);
	modport sink (
		input  valid, service_active, line_one_active, line_two_active,
		       line_three_active, line_four_active, coin_present,
		output ready
	);
endinterface

`default_nettype wire

>>> design/chpc_result_if.sv
// Coin hopper payout controller: result channel (valid/ready + outputs).
// Depends on nothing.
`default_nettype none

interface chpc_result_if;
	logic       valid;
	logic       ready;
	logic       motor_on;
	logic       accept_enabled;
	logic       paying;
	logic       fault;
	logic [7:0] coins_paid;
	logic       payout_done;

	modport source (
		output valid, motor_on, accept_enabled, paying, fault, coins_paid, payout_done,
		input  ready
	);
	modport sink (
		input  valid, motor_on, accept_enabled, paying, fault, coins_paid, payout_done,
		output ready
	);
endinterface

`default_nettype wire

>>> design/chpc_cfg_if.sv
// Coin hopper payout controller: configuration write channel.
// Depends on nothing.
`default_nettype none

interface chpc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/chpc_cfg_regs.sv
// Coin hopper payout controller: configuration register file.
// Depends on chpc_pkg.
`default_nettype none

module chpc_cfg_regs
	import chpc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire logic [CfgIdxW-1:0]  wr_index,
	input  wire logic [CfgDataW-1:0] wr_data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coins_line[0] <= CoinsLineOneRst;
			cfg_q.coins_line[1] <= CoinsLineTwoRst;
			cfg_q.coins_line[2] <= CoinsLineThreeRst;
			cfg_q.coins_line[3] <= CoinsLineFourRst;
			cfg_q.timeout_ticks <= TimeoutTicksRst;
		end else if (wr_en) begin
			unique case (wr_index)
				RegCoinsLineOne:   cfg_q.coins_line[0] <= wr_data[CoinW-1:0];
				RegCoinsLineTwo:   cfg_q.coins_line[1] <= wr_data[CoinW-1:0];
				RegCoinsLineThree: cfg_q.coins_line[2] <= wr_data[CoinW-1:0];
				RegCoinsLineFour:  cfg_q.coins_line[3] <= wr_data[CoinW-1:0];
				RegTimeoutTicks:   cfg_q.timeout_ticks <= wr_data[TicksW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> design/chpc_ctrl.sv
// Coin hopper payout controller: payout state and per-tick update logic.
// Depends on chpc_pkg.
`default_nettype none

module chpc_ctrl
	import chpc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  tick_en,
	input  wire tick_t tick,
	input  wire cfg_t  cfg,
	output result_t    result
);

	logic [1:0]          mode_q, mode_d;
	logic [CoinW-1:0]    target_q, target_d;
	logic [CoinW-1:0]    count_q, count_d;
	logic                armed_q, armed_d;
	logic [TicksW-1:0]   ticks_q, ticks_d;
	logic [NumLines-1:0] prev_lines_q;
	logic                prev_coin_q;

	logic [NumLines-1:0] qual;
	logic                coin_hit;
	logic                motor;
	logic                done;

	assign qual     = tick.lines & prev_lines_q;
	assign coin_hit = tick.coin_present & prev_coin_q & armed_q;

	always_comb begin
		mode_d   = mode_q;
		target_d = target_q;
		count_d  = count_q;
		armed_d  = armed_q;
		ticks_d  = ticks_q;
		motor    = 1'b0;
		done     = 1'b0;
		unique case (mode_q)
			ModeIdle: begin
				if (tick.service_active) begin
					motor = 1'b1;
				end else if (qual != '0) begin
					priority if (qual[0]) target_d = cfg.coins_line[0];
					else if (qual[1])     target_d = cfg.coins_line[1];
					else if (qual[2])     target_d = cfg.coins_line[2];
					else                  target_d = cfg.coins_line[3];
					count_d = '0;
					ticks_d = '0;
					mode_d  = ModePaying;
				end
			end
			ModePaying: begin
				if (ticks_q != TicksMax) begin
					ticks_d = ticks_q + 1'b1;
				end
				if (coin_hit) begin
					armed_d = 1'b0;
					count_d = count_q + 1'b1;
					ticks_d = '0;
				end else if (!tick.coin_present && !prev_coin_q && !armed_q) begin
					armed_d = 1'b1;
				end
				if (ticks_d >= cfg.timeout_ticks) begin
					mode_d = ModeFault;
				end else if (count_d == target_q) begin
					mode_d = ModeIdle;
					done   = 1'b1;
				end
			end
			ModeFault: ;
			default: mode_d = ModeIdle;
		endcase
		if (mode_d != ModePaying && !tick.coin_present && !prev_coin_q) begin
			armed_d = 1'b1;
		end
	end

	always_comb begin
		result.motor_on       = motor;
		result.accept_enabled = 1'b1;
		if (mode_d == ModePaying) begin
			result.motor_on       = 1'b1;
			result.accept_enabled = 1'b0;
		end else if (mode_d == ModeFault) begin
			result.motor_on       = 1'b0;
			result.accept_enabled = 1'b0;
		end
		result.paying      = (mode_d == ModePaying);
		result.fault       = (mode_d == ModeFault);
		result.coins_paid  = count_d;
		result.payout_done = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= ModeIdle;
			target_q     <= '0;
			count_q      <= '0;
			armed_q      <= 1'b1;
			ticks_q      <= '0;
			prev_lines_q <= '0;
			prev_coin_q  <= 1'b0;
		end else if (tick_en) begin
			mode_q       <= mode_d;
			target_q     <= target_d;
			count_q      <= count_d;
			armed_q      <= armed_d;
			ticks_q      <= ticks_d;
			prev_lines_q <= tick.lines;
			prev_coin_q  <= tick.coin_present;
		end
	end

endmodule

`default_nettype wire

>>> design/chpc_out_buf.sv
// Coin hopper payout controller: two-entry result buffer between the
// controller and the result channel.
// Depends on chpc_pkg.
`default_nettype none

module chpc_out_buf
	import chpc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wr_en,
	input  wire result_t wr_data,
	output logic         full,
	output logic         rd_valid,
	input  wire logic    rd_ready,
	output result_t      rd_data
);

	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       rd_en;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_en    = rd_valid & rd_ready;
	assign rd_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en) rd_ptr_q <= ~rd_ptr_q;
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/coin_hopper_payout_controller_unit.sv
// Coin hopper payout controller, top level.
// Depends on chpc_pkg, chpc_tick_if, chpc_result_if, chpc_cfg_if, chpc_cfg_regs,
// chpc_ctrl and chpc_out_buf.
//
// One transaction on tick_in per millisecond tick gives exactly one transaction on
// result_out. The whole state update for a tick is done in the cycle the tick is
// accepted and the result lands in a two-entry output buffer, so a tick can be
// taken every clock cycle; tick_in.ready drops only while both buffer entries wait
// to be taken. Configuration writes are accepted every cycle (cfg.ready is tied
// high); indexes above four are ignored.
`default_nettype none

module coin_hopper_payout_controller_unit
	import chpc_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	chpc_tick_if.sink    tick_in,
	chpc_result_if.source result_out,
	chpc_cfg_if.sink     cfg
);

	cfg_t    cfg_regs;
	tick_t   tick;
	result_t result;
	result_t buf_data;
	logic    buf_full;
	logic    tick_en;

	assign cfg.ready     = 1'b1;
	assign tick_in.ready = ~buf_full;
	assign tick_en       = tick_in.valid & ~buf_full;

	assign tick.service_active = tick_in.service_active;
	assign tick.lines          = {tick_in.line_four_active, tick_in.line_three_active,
	                              tick_in.line_two_active, tick_in.line_one_active};
	assign tick.coin_present   = tick_in.coin_present;

	chpc_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	chpc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick_en (tick_en),
		.tick    (tick),
		.cfg     (cfg_regs),
		.result  (result)
	);

	chpc_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (tick_en),
		.wr_data  (result),
		.full     (buf_full),
		.rd_valid (result_out.valid),
		.rd_ready (result_out.ready),
		.rd_data  (buf_data)
	);

	assign result_out.motor_on       = buf_data.motor_on;
	assign result_out.accept_enabled = buf_data.accept_enabled;
	assign result_out.paying         = buf_data.paying;
	assign result_out.fault          = buf_data.fault;
	assign result_out.coins_paid     = buf_data.coins_paid;
	assign result_out.payout_done    = buf_data.payout_done;

endmodule

`default_nettype wire

>>> dv/chpc_payout_checker.sv
`timescale 1ns / 1ps
// Checker for the coin hopper payout controller: watches the tick, result and
// register channels, predicts each result and compares it with what comes out.
// Depends on chpc_pkg and the three channel interfaces.

module chpc_payout_checker
	import chpc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	chpc_tick_if     tick_mon,
	chpc_result_if   result_mon,
	chpc_cfg_if      cfg_mon,
	output int       fail_count,
	output int       pending
);

	logic [CoinW-1:0]    coins_per_line [NumLines];
	logic [TicksW-1:0]   payout_timeout;

	logic [1:0]          hop_mode;
	logic [CoinW-1:0]    hop_target;
	logic [CoinW-1:0]    hop_count;
	logic                hop_armed;
	logic [TicksW-1:0]   hop_idle;
	logic [NumLines-1:0] hop_prev_lines;
	logic                hop_prev_coin;

	result_t expected_results [$];
	int      mismatches;
	int      results_seen;

	assign fail_count = mismatches;

	function automatic result_t predict_tick(input tick_t t);
		result_t             r;
		logic [NumLines-1:0] qual;
		logic                motor;
		logic                accept;
		logic                done;
		logic                started;
		motor   = 1'b0;
		accept  = 1'b1;
		done    = 1'b0;
		started = 1'b0;
		if (hop_mode == ModeIdle) begin
			if (t.service_active) begin
				motor = 1'b1;
			end else begin
				qual = t.lines & hop_prev_lines;
				for (int k = 0; k < NumLines; k++) begin
					if (qual[k] && !started) begin
						hop_target = coins_per_line[k];
						hop_count  = '0;
						hop_idle   = '0;
						hop_mode   = ModePaying;
						started    = 1'b1;
					end
				end
			end
		end else if (hop_mode == ModePaying) begin
			if (hop_idle != TicksMax)
				hop_idle = hop_idle + 1'b1;
			if (t.coin_present && hop_prev_coin && hop_armed) begin
				hop_armed = 1'b0;
				hop_count = hop_count + 1'b1;
				hop_idle  = '0;
			end else if (!t.coin_present && !hop_prev_coin && !hop_armed) begin
				hop_armed = 1'b1;
			end
			if (hop_idle >= payout_timeout) begin
				hop_mode = ModeFault;
			end else if (hop_count == hop_target) begin
				hop_mode = ModeIdle;
				done     = 1'b1;
			end
		end else if (hop_mode != ModeFault) begin
			hop_mode = ModeIdle;
		end

		if (hop_mode != ModePaying && !t.coin_present && !hop_prev_coin)
			hop_armed = 1'b1;
		hop_prev_lines = t.lines;
		hop_prev_coin  = t.coin_present;

		if (hop_mode == ModePaying) begin
			motor  = 1'b1;
			accept = 1'b0;
		end else if (hop_mode == ModeFault) begin
			motor  = 1'b0;
			accept = 1'b0;
		end
		r.motor_on       = motor;
		r.accept_enabled = accept;
		r.paying         = (hop_mode == ModePaying);
		r.fault          = (hop_mode == ModeFault);
		r.coins_paid     = hop_count;
		r.payout_done    = done;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t seen;
		result_t want;
		tick_t   t;
		if (!arst_n) begin
			coins_per_line = '{CoinsLineOneRst, CoinsLineTwoRst, CoinsLineThreeRst,
			                   CoinsLineFourRst};
			payout_timeout = TimeoutTicksRst;
			hop_mode       = ModeIdle;
			hop_target     = '0;
			hop_count      = '0;
			hop_armed      = 1'b1;
			hop_idle       = '0;
			hop_prev_lines = '0;
			hop_prev_coin  = 1'b0;
			expected_results.delete();
			mismatches     = 0;
			results_seen   = 0;
			pending       <= 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) begin
				case (cfg_mon.index)
					RegCoinsLineOne:   coins_per_line[0] = cfg_mon.data[CoinW-1:0];
					RegCoinsLineTwo:   coins_per_line[1] = cfg_mon.data[CoinW-1:0];
					RegCoinsLineThree: coins_per_line[2] = cfg_mon.data[CoinW-1:0];
					RegCoinsLineFour:  coins_per_line[3] = cfg_mon.data[CoinW-1:0];
					RegTimeoutTicks:   payout_timeout    = cfg_mon.data;
					default: ;
				endcase
			end

			if (tick_mon.valid && tick_mon.ready) begin
				t.service_active = tick_mon.service_active;
				t.lines          = {tick_mon.line_four_active, tick_mon.line_three_active,
				                    tick_mon.line_two_active, tick_mon.line_one_active};
				t.coin_present   = tick_mon.coin_present;
				expected_results.push_back(predict_tick(t));
			end

			if (result_mon.valid && result_mon.ready) begin
				seen.motor_on       = result_mon.motor_on;
				seen.accept_enabled = result_mon.accept_enabled;
				seen.paying         = result_mon.paying;
				seen.fault          = result_mon.fault;
				seen.coins_paid     = result_mon.coins_paid;
				seen.payout_done    = result_mon.payout_done;
				if (expected_results.size() == 0) begin
					if (mismatches < 10)
						$display("result %0d with no tick outstanding: motor=%b accept=%b paying=%b fault=%b coins=%0d done=%b",
						         results_seen, seen.motor_on, seen.accept_enabled,
						         seen.paying, seen.fault, seen.coins_paid, seen.payout_done);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (seen.motor_on !== want.motor_on ||
					    seen.accept_enabled !== want.accept_enabled ||
					    seen.paying !== want.paying || seen.fault !== want.fault ||
					    seen.coins_paid !== want.coins_paid ||
					    seen.payout_done !== want.payout_done) begin
						if (mismatches < 10)
							$display("result %0d: expected motor=%b accept=%b paying=%b fault=%b coins=%0d done=%b, got motor=%b accept=%b paying=%b fault=%b coins=%0d done=%b",
							         results_seen, want.motor_on, want.accept_enabled,
							         want.paying, want.fault, want.coins_paid,
							         want.payout_done, seen.motor_on, seen.accept_enabled,
							         seen.paying, seen.fault, seen.coins_paid,
							         seen.payout_done);
						mismatches++;
					end
				end
				results_seen++;
			end
			pending <= expected_results.size();
		end
	end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the coin hopper payout controller bench: clock, reset, register writes,
// tick stimulus, result back-pressure and the verdict.
// Depends on chpc_pkg, the channel interfaces, the unit and chpc_payout_checker.

module tb_top;
	import chpc_pkg::*;

	logic clk;
	logic arst_n;

	chpc_tick_if   tick_in ();
	chpc_result_if result_out ();
	chpc_cfg_if    cfg ();

	int  fail_count;
	int  pending_results;
	int  ticks_sent;
	bit  no_idle;
	bit  sender_gaps_on;
	bit  long_hold_req;

	logic [CoinW-1:0] line_coins [NumLines];

	// bits: service, lines four..one, coin
	tick_t directed_ticks [28] = '{
		6'b0_0000_0, 6'b0_0000_0, 6'b1_0000_0, 6'b1_1111_0, 6'b0_1111_0, 6'b0_0000_1,
		6'b0_0000_1, 6'b0_0100_0, 6'b0_0110_0, 6'b1_0000_1, 6'b0_0000_0, 6'b0_0000_0,
		6'b0_1111_1, 6'b0_1111_1, 6'b0_1111_1, 6'b0_1111_0, 6'b0_1111_0, 6'b0_1111_1,
		6'b0_1111_1, 6'b0_1111_0, 6'b0_1111_0, 6'b0_1111_1, 6'b0_1111_1, 6'b0_0011_0,
		6'b0_0000_0, 6'b0_0000_0, 6'b0_0000_1, 6'b0_0000_1
	};

	// single-tick timeout: a payout of one coin that must count on its first tick
	tick_t quick_payout_ticks [7] = '{
		6'b0_0000_0, 6'b0_0000_0, 6'b0_0001_0, 6'b0_0001_1, 6'b0_0000_1,
		6'b0_0000_0, 6'b0_0000_0
	};

	coin_hopper_payout_controller_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_in    (tick_in),
		.result_out (result_out),
		.cfg        (cfg)
	);

	chpc_payout_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_mon   (tick_in),
		.result_mon (result_out),
		.cfg_mon    (cfg),
		.fail_count (fail_count),
		.pending    (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

	// result side back-pressure
	initial begin
		int stall_left;
		stall_left = 0;
		result_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_out.ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = 150;
				result_out.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 13) - 1;
				result_out.ready <= 1'b0;
			end else begin
				result_out.ready <= 1'b1;
			end
		end
	end

	function automatic tick_t mk_tick(input bit s, input bit [NumLines-1:0] l, input bit c);
		return {s, l, c};
	endfunction

	task automatic send_tick(input tick_t t);
		if (sender_gaps_on && !no_idle && $urandom_range(0, 6) == 0) begin
			tick_in.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		tick_in.valid             <= 1'b1;
		tick_in.service_active    <= t.service_active;
		tick_in.line_one_active   <= t.lines[0];
		tick_in.line_two_active   <= t.lines[1];
		tick_in.line_three_active <= t.lines[2];
		tick_in.line_four_active  <= t.lines[3];
		tick_in.coin_present      <= t.coin_present;
		do @(posedge clk); while (!tick_in.ready);
		ticks_sent++;
	endtask

	task automatic wait_drained;
		tick_in.valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic program_regs(input logic [CoinW-1:0] c1, input logic [CoinW-1:0] c2,
	                            input logic [CoinW-1:0] c3, input logic [CoinW-1:0] c4,
	                            input logic [TicksW-1:0] tmo);
		line_coins = '{c1, c2, c3, c4};
		cfg.valid <= 1'b1;
		put_reg(RegCoinsLineOne, CfgDataW'(c1));
		put_reg(RegCoinsLineTwo, CfgDataW'(c2));
		put_reg(RegCoinsLineThree, CfgDataW'(c3));
		put_reg(RegCoinsLineFour, CfgDataW'(c4));
		put_reg(RegTimeoutTicks, tmo);
		put_reg(CfgIdxW'($urandom_range(RegTimeoutTicks + 1, (1 << CfgIdxW) - 1)),
		        CfgDataW'($urandom));
		cfg.valid <= 1'b0;
	endtask

	// clean coin pulses that finish any payout of up to n-1 coins
	task automatic settle_coins(input int n);
		repeat (n) begin
			repeat (2) send_tick(mk_tick(1'b0, '0, 1'b0));
			repeat (2) send_tick(mk_tick(1'b0, '0, 1'b1));
		end
	endtask

	task automatic payout_episode(input bit line_one_only);
		bit [NumLines-1:0] credit;
		bit [NumLines-1:0] stray;
		int                wanted;
		credit = NumLines'($urandom_range(1, (1 << NumLines) - 1));
		if (line_one_only)
			credit[0] = 1'b1;
		wanted = 1;
		for (int k = NumLines - 1; k >= 0; k--)
			if (credit[k])
				wanted = line_coins[k] + 1;
		repeat ($urandom_range(2, 3))
			send_tick(mk_tick($urandom_range(0, 7) == 0, credit, 1'b0));
		repeat (wanted) begin
			repeat ($urandom_range(1, 3)) begin
				stray = (!line_one_only && $urandom_range(0, 5) == 0) ? NumLines'($urandom) : '0;
				send_tick(mk_tick($urandom_range(0, 5) == 0, stray, 1'b0));
			end
			repeat ($urandom_range(1, 3)) begin
				stray = (!line_one_only && $urandom_range(0, 5) == 0) ? NumLines'($urandom) : '0;
				send_tick(mk_tick($urandom_range(0, 5) == 0, stray, 1'b1));
			end
		end
	endtask

	task automatic random_payouts(input int n, input bit line_one_only);
		int stop_at;
		stop_at = ticks_sent + n;
		while (ticks_sent < stop_at) begin
			if (!line_one_only && $urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 5)) send_tick(tick_t'($urandom));
			end else begin
				payout_episode(line_one_only);
			end
		end
	endtask

	initial begin
		int guard;
		arst_n                    <= 1'b0;
		tick_in.valid             <= 1'b0;
		tick_in.service_active    <= 1'b0;
		tick_in.line_one_active   <= 1'b0;
		tick_in.line_two_active   <= 1'b0;
		tick_in.line_three_active <= 1'b0;
		tick_in.line_four_active  <= 1'b0;
		tick_in.coin_present      <= 1'b0;
		cfg.valid                 <= 1'b0;
		cfg.index                 <= RegCoinsLineOne;
		cfg.data                  <= '0;
		ticks_sent     = 0;
		no_idle        = 1'b0;
		sender_gaps_on = 1'b1;
		long_hold_req  = 1'b0;
		line_coins     = '{CoinsLineOneRst, CoinsLineTwoRst, CoinsLineThreeRst,
		                   CoinsLineFourRst};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, line one payouts only
		random_payouts(30, 1'b1);
		settle_coins(CoinsLineOneRst + 1);
		wait_drained();

		program_regs(8'd1, 8'd2, 8'd3, 8'd4, TicksMax);
		foreach (directed_ticks[i])
			send_tick(directed_ticks[i]);
		random_payouts(60, 1'b0);
		settle_coins(5);
		wait_drained();

		program_regs(8'd1, 8'd1, 8'd1, 8'd1, 16'd1);
		foreach (quick_payout_ticks[i])
			send_tick(quick_payout_ticks[i]);
		wait_drained();

		program_regs(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
		             8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
		             16'($urandom_range(200, 2000)));
		// long result stall with the tick side kept busy
		long_hold_req  = 1'b1;
		sender_gaps_on = 1'b0;
		random_payouts(30, 1'b0);
		sender_gaps_on = 1'b1;
		random_payouts(40, 1'b0);
		wait_drained();
		random_payouts(20, 1'b0);
		settle_coins(7);
		wait_drained();

		program_regs(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
		             8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
		             16'($urandom_range(200, TicksMax)));
		random_payouts(40, 1'b0);
		settle_coins(7);
		wait_drained();

		// largest target on line four, then let it time out into a lasting fault
		no_idle = 1'b1;
		program_regs(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
		             8'($urandom_range(1, 6)), 8'd255, 16'd60);
		repeat (2) send_tick(mk_tick(1'b0, 4'b1000, 1'b0));
		repeat (8) begin
			repeat ($urandom_range(2, 3)) send_tick(mk_tick(1'b0, '0, 1'b0));
			repeat ($urandom_range(2, 3)) send_tick(mk_tick(1'b0, '0, 1'b1));
		end
		repeat (70) send_tick(mk_tick($urandom_range(0, 3) == 0, '0, 1'b0));
		repeat (20) send_tick(tick_t'($urandom));

		tick_in.valid <= 1'b0;
		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (pending_results != 0 && guard < 5000);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending_results == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
design/chpc_pkg.sv
design/chpc_tick_if.sv
design/chpc_result_if.sv
design/chpc_cfg_if.sv
design/chpc_cfg_regs.sv
design/chpc_ctrl.sv
design/chpc_out_buf.sv
design/coin_hopper_payout_controller_unit.sv
dv/chpc_payout_checker.sv
dv/tb_top.sv
